// ----- design/multi_level_hash_set_defines.svh -----
// Assertion macros shared by the checker of the multi-level hash set
`ifndef MULTI_LEVEL_HASH_SET_DEFINES_SVH
`define MULTI_LEVEL_HASH_SET_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define MLHS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define MLHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/mlhs_pkg.sv -----
// Package of the multi-level hash set: sizes, codes and hash helpers
package mlhs_pkg;

    localparam int LEVELS      = 4;
    localparam int BASE_SLOTS  = 256;
    localparam int MAX_PROBES  = 7;
    localparam int TOTAL_SLOTS = BASE_SLOTS * ((1 << LEVELS) - 1);
    localparam int ADDR_W      = $clog2(TOTAL_SLOTS);
    localparam int LVL_W       = 2;
    localparam int SLOT_W      = 11;
    localparam int PI_W        = 3;
    localparam int KEY_W       = 64;
    localparam int SEED_W      = 32;
    localparam int IDX_W       = 4;
    localparam int IN_W        = 72;
    localparam int OUT_W       = 16;

    // Murmur constants
    localparam logic [31:0] C_K1  = 32'hcc9e2d51;
    localparam logic [31:0] C_K2  = 32'h1b873593;
    localparam logic [31:0] C_H5  = 32'd5;
    localparam logic [31:0] C_ADD = 32'he6546b64;
    localparam logic [31:0] C_LEN = 32'd4;
    localparam logic [31:0] C_F1  = 32'h85ebca6b;
    localparam logic [31:0] C_F2  = 32'hc2b2ae35;

    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_QUERY  = 2'd1,
        FN_DELETE = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_LIVE  = 2'd1,
        TAG_TOMB  = 2'd2,
        TAG_RSVD  = 2'd3
    } t_tag;

    typedef enum logic [1:0] {
        OC_NO   = 2'd0,
        OC_YES  = 2'd1,
        OC_FULL = 2'd2,
        OC_RSVD = 2'd3
    } t_outcome;

    localparam logic [IDX_W-1:0] REG_PROBE_COUNT = 4'd0;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

endpackage

// ----- design/multi_level_hash_set.sv -----
// Multi-level hash set: insert, query and delete of 64-bit keys
//
// Channels: the slave stream takes one operation per transaction
// (func, key); the master stream returns one result per operation
// (outcome, level_hit, slot_hit). The config channel writes register
// i_cfg_index (0 probe count, 1..7 seeds) and is always ready; write it
// only while no operation is in flight.
// Sequence: the clamped probe count (1..7) sets how many seeds are
// hashed, and an operation probes 1..16 slots. The shared 32x32
// multiplier serves the hashing part (four steps per seed); each probe
// reads the tag/key store and then checks its registered read data.
// The slave side is not ready until the result is handed over to the
// output register; that register lets the next operation in while a
// result still waits.
// Reset: probe count 1, seeds 0, then a clearing pass marks every slot
// empty; no operation is taken meanwhile.
// Stall: when the master side holds tready low, the result stays in the
// output register and the block finishes at most one more operation.
module multi_level_hash_set (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [mlhs_pkg::IN_W-1:0] i_s_tdata,   // [1:0] func, [65:2] key
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [mlhs_pkg::OUT_W-1:0] o_m_tdata,  // [1:0] outcome, [3:2] level_hit,
                                                   // [14:4] slot_hit
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [mlhs_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [mlhs_pkg::SEED_W-1:0] i_cfg_data
);
    import mlhs_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_K1, S_K2, S_H1, S_H2, S_H3, S_H4, S_RD, S_CHK, S_DONE
    } t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_clr;
    logic [PI_W-1:0]     r_pc;
    logic [PI_W-1:0]     r_probe_cnt;
    logic [SEED_W-1:0]   r_seed [MAX_PROBES];
    logic [31:0]         r_bkt [MAX_PROBES];
    t_func               r_func;
    logic [KEY_W-1:0]    r_key;
    logic [31:0]         r_h;
    logic [31:0]         r_k;
    logic [PI_W-1:0]     r_pi;
    logic [LVL_W-1:0]    r_lvl;
    logic [ADDR_W-1:0]   r_addr;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_have_tomb;
    logic [ADDR_W-1:0]   r_tomb_addr;
    logic [LVL_W-1:0]    r_tomb_lvl;
    logic [SLOT_W-1:0]   r_tomb_slot;
    t_outcome            r_oc;
    logic [LVL_W-1:0]    r_res_lvl;
    logic [SLOT_W-1:0]   r_res_slot;
    logic                r_ovalid;
    logic [OUT_W-1:0]    r_odata;

    t_tag                r_tag_q;
    logic [KEY_W-1:0]    r_key_q;
    logic [1:0]          mem_tag [TOTAL_SLOTS];
    logic [KEY_W-1:0]    mem_key [TOTAL_SLOTS];

    logic [31:0]         w_mul_a;
    logic [31:0]         w_mul_b;
    logic [63:0]         w_prod;
    logic [31:0]         w_t;
    logic [SLOT_W-1:0]   w_slot;
    logic [ADDR_W-1:0]   w_addr;
    logic [PI_W:0]       w_limit;
    logic                w_last;
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    t_tag                w_wtag;
    logic                w_kwe;
    logic                w_match;
    logic                w_new_tomb;
    logic [PI_W-1:0]     w_pc_in;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;

    // Clamp the probe count for an incoming operation
    always_comb begin
        if (r_probe_cnt == '0) begin
            w_pc_in = PI_W'(1);
        end else if (32'(r_probe_cnt) > MAX_PROBES) begin
            w_pc_in = PI_W'(MAX_PROBES);
        end else begin
            w_pc_in = r_probe_cnt;
        end
    end

    // Select operands of the shared multiplier
    always_comb begin
        w_t     = '0;
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_K1: begin
                w_mul_a = r_key[31:0];
                w_mul_b = C_K1;
            end
            S_K2: begin
                w_mul_a = rotl32(r_h, 15);
                w_mul_b = C_K2;
            end
            S_H1: begin
                w_mul_a = rotl32(r_seed[r_pi] ^ r_k, 13);
                w_mul_b = C_H5;
            end
            S_H2: begin
                w_t     = (r_h + C_ADD) ^ C_LEN;
                w_mul_a = w_t ^ (w_t >> 16);
                w_mul_b = C_F1;
            end
            S_H3: begin
                w_mul_a = r_h ^ (r_h >> 13);
                w_mul_b = C_F2;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
        w_prod = w_mul_a * w_mul_b;
    end

    // Form the slot and store address of the current probe
    always_comb begin
        w_slot  = SLOT_W'((32'(BASE_SLOTS) << r_lvl) - 32'd1) & r_bkt[r_pi][SLOT_W-1:0];
        w_addr  = ADDR_W'((32'(BASE_SLOTS) << r_lvl) - 32'(BASE_SLOTS)) + ADDR_W'(w_slot);
        w_limit = {1'b0, r_lvl, 1'b1};
        if (w_limit > {1'b0, r_pc}) begin
            w_limit = {1'b0, r_pc};
        end
        w_last  = ({1'b0, r_pi} + 1'b1) >= w_limit;
        w_match = (r_tag_q == TAG_LIVE) && (r_key_q == r_key);
        // first dead slot of an insert met at this probe
        w_new_tomb = (r_func == FN_INSERT) && !r_have_tomb &&
                     (r_tag_q != TAG_LIVE) && (r_tag_q != TAG_EMPTY);
    end

    // Decide store writes: clearing pass, insert, delete
    always_comb begin
        w_we    = 1'b0;
        w_kwe   = 1'b0;
        w_waddr = r_addr;
        w_wtag  = TAG_LIVE;
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wtag  = TAG_EMPTY;
        end else if (r_state == S_CHK) begin
            if (r_tag_q == TAG_EMPTY || (!w_match && w_last && r_lvl == LVL_W'(LEVELS - 1))) begin
                if (r_func == FN_INSERT &&
                    (r_tag_q == TAG_EMPTY || r_have_tomb || w_new_tomb)) begin
                    w_we    = 1'b1;
                    w_kwe   = 1'b1;
                    w_waddr = r_have_tomb ? r_tomb_addr : r_addr;
                end
            end else if (w_match && r_func == FN_DELETE) begin
                w_we   = 1'b1;
                w_wtag = TAG_TOMB;
            end
        end
    end

    // Tag and key store, read data registered
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_tag[w_waddr] <= w_wtag;
        end
        r_tag_q <= t_tag'(mem_tag[w_addr]);
    end

    always_ff @(posedge i_clk) begin
        if (w_kwe) begin
            mem_key[w_waddr] <= r_key;
        end
        r_key_q <= mem_key[w_addr];
    end

    // Sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_probe_cnt <= PI_W'(1);
            for (int i = 0; i < MAX_PROBES; i++) begin
                r_seed[i] <= '0;
            end
            r_ovalid    <= 1'b0;
            r_have_tomb <= 1'b0;
        end else begin
            // take configuration writes; indexes past the seeds drop
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_PROBE_COUNT) begin
                    r_probe_cnt <= i_cfg_data[PI_W-1:0];
                end else if (32'(i_cfg_index) <= MAX_PROBES) begin
                    r_seed[PI_W'(i_cfg_index - 1'b1)] <= i_cfg_data;
                end
            end
            // release the output register; a hand-over below refills it
            if (r_ovalid && i_m_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == ADDR_W'(TOTAL_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_func      <= t_func'(i_s_tdata[1:0]);
                        r_key       <= i_s_tdata[KEY_W+1:2];
                        r_pc        <= w_pc_in;
                        r_pi        <= '0;
                        r_lvl       <= '0;
                        r_have_tomb <= 1'b0;
                        if (t_func'(i_s_tdata[1:0]) == FN_NONE) begin
                            r_oc       <= OC_NO;
                            r_res_lvl  <= '0;
                            r_res_slot <= '0;
                            r_state    <= S_DONE;
                        end else begin
                            r_state <= S_K1;
                        end
                    end
                end
                S_K1: begin
                    r_h     <= w_prod[31:0];
                    r_state <= S_K2;
                end
                S_K2: begin
                    r_k     <= w_prod[31:0];
                    r_state <= S_H1;
                end
                S_H1: begin
                    r_h     <= w_prod[31:0];
                    r_state <= S_H2;
                end
                S_H2: begin
                    r_h     <= w_prod[31:0];
                    r_state <= S_H3;
                end
                S_H3: begin
                    r_h     <= w_prod[31:0];
                    r_state <= S_H4;
                end
                S_H4: begin
                    r_bkt[r_pi] <= r_h ^ (r_h >> 16);
                    if (r_pi + 1'b1 < r_pc) begin
                        r_pi    <= r_pi + 1'b1;
                        r_state <= S_H1;
                    end else begin
                        r_pi    <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_addr  <= w_addr;
                    r_slot  <= w_slot;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_state <= S_DONE;
                    if (r_tag_q == TAG_EMPTY) begin
                        if (r_func == FN_INSERT) begin
                            r_oc       <= OC_YES;
                            r_res_lvl  <= r_have_tomb ? r_tomb_lvl : r_lvl;
                            r_res_slot <= r_have_tomb ? r_tomb_slot : r_slot;
                        end else begin
                            r_oc       <= OC_NO;
                            r_res_lvl  <= r_lvl;
                            r_res_slot <= r_slot;
                        end
                    end else if (w_match) begin
                        r_oc       <= (r_func == FN_INSERT) ? OC_NO : OC_YES;
                        r_res_lvl  <= r_lvl;
                        r_res_slot <= r_slot;
                    end else begin
                        // remember the first dead slot for an insert
                        if (w_new_tomb) begin
                            r_have_tomb <= 1'b1;
                            r_tomb_addr <= r_addr;
                            r_tomb_lvl  <= r_lvl;
                            r_tomb_slot <= r_slot;
                        end
                        if (!w_last) begin
                            r_pi    <= r_pi + 1'b1;
                            r_state <= S_RD;
                        end else if (r_lvl != LVL_W'(LEVELS - 1)) begin
                            r_pi    <= '0;
                            r_lvl   <= r_lvl + 1'b1;
                            r_state <= S_RD;
                        end else if (r_func == FN_INSERT && (r_have_tomb || w_new_tomb)) begin
                            r_oc       <= OC_YES;
                            r_res_lvl  <= r_have_tomb ? r_tomb_lvl : r_lvl;
                            r_res_slot <= r_have_tomb ? r_tomb_slot : r_slot;
                        end else begin
                            r_oc       <= (r_func == FN_INSERT) ? OC_FULL : OC_NO;
                            r_res_lvl  <= '0;
                            r_res_slot <= '0;
                        end
                    end
                end
                S_DONE: begin
                    // hand over once the output register is free
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {1'b0, r_res_slot, r_res_lvl, r_oc};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- design/mlhs_checker.sv -----
// Port checker of the multi-level hash set, bound to the top level
`include "multi_level_hash_set_defines.svh"

module mlhs_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_tvalid,
    input logic                       o_s_tready,
    input logic                       o_m_tvalid,
    input logic                       i_m_tready,
    input logic [mlhs_pkg::OUT_W-1:0] o_m_tdata
);
    import mlhs_pkg::*;

    // Hold a stalled result
    `MLHS_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "result dropped under stall")

    // One operation at a time: no second transaction right after one
    `MLHS_ASSERT_NEXT(a_busy, i_s_tvalid && o_s_tready, !o_s_tready, "ready right after a transaction")

    // Outcome code is never the reserved one
    `MLHS_ASSERT_NOW(a_outcome, o_m_tvalid, o_m_tdata[1:0] != OC_RSVD, "reserved outcome")

endmodule

bind multi_level_hash_set mlhs_checker u_mlhs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
